>>> src/fbsac_pkg.sv
// Package: constants, opcodes and the command word passed from front to back.
package fbsac_pkg;

    localparam int MAX_PAYLOAD = 20;
    localparam int REM_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int IDX_W       = 3;

    localparam logic [7:0] LEN_MAX   = 8'(MAX_PAYLOAD);
    localparam logic [7:0] HDR_SYNC0 = 8'hAA;
    localparam logic [7:0] HDR_SYNC1 = 8'hFF;
    localparam logic [7:0] HDR_FUNC  = 8'hF0;
    localparam logic [7:0] CODE_MIN  = 8'd1;
    localparam logic [7:0] CODE_MAX  = 8'd10;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Header byte positions
    localparam logic [IDX_W-1:0] IDX_SYNC0 = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SYNC1 = 3'd1;
    localparam logic [IDX_W-1:0] IDX_FUNC  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_LEN   = 3'd3;
    localparam logic [IDX_W-1:0] HDR_BYTES = 3'd4;
    localparam logic [IDX_W-1:0] PAY_BYTES = 3'd1;

    typedef struct packed {
        logic       is_start;
        logic [7:0] value;     // function byte on start, data byte otherwise
        logic [7:0] len;       // saturated length, start only
        logic       closes;    // check bytes follow this command
    } t_cmd;

endpackage

>>> src/fbsac_if.sv
// Stream interfaces for the input item channel and the output byte channel.
interface fbsac_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] function_code;
    logic [7:0] frame_length;
    logic [7:0] data_byte;

    modport source (output valid, opcode, function_code, frame_length, data_byte,
                    input ready);
    modport sink   (input valid, opcode, function_code, frame_length, data_byte,
                    output ready);
endinterface

interface fbsac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_frame;

    modport source (output valid, out_byte, last_of_frame, input ready);
    modport sink   (input valid, out_byte, last_of_frame, output ready);
endinterface

>>> src/fbsac_front.sv
// Front end: accepts input words, tracks frame state, emits commands to the queue.
module fbsac_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fbsac_in_if.sink            i_in,
    input  logic                i_full,
    output logic                o_push,
    output fbsac_pkg::t_cmd     o_cmd
);
    import fbsac_pkg::*;

    logic             r_open, n_open;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             accept;
    logic [7:0]       len_sat;
    logic [7:0]       fbyte;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        len_sat = (i_in.frame_length > LEN_MAX) ? LEN_MAX : i_in.frame_length;
        fbyte   = HDR_FUNC;
        if (i_in.function_code >= CODE_MIN && i_in.function_code <= CODE_MAX) begin
            fbyte = HDR_FUNC | i_in.function_code;
        end
    end

    always_comb begin
        n_open = r_open;
        n_rem  = r_rem;
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            if (i_in.opcode == OP_START) begin
                o_push         = 1'b1;
                o_cmd.is_start = 1'b1;
                o_cmd.value    = fbyte;
                o_cmd.len      = len_sat;
                o_cmd.closes   = (len_sat == 8'd0);
                n_open         = (len_sat != 8'd0);
                n_rem          = len_sat[REM_W-1:0];
            end else if (r_open && r_rem != '0) begin
                // stray payload outside a frame is dropped here
                o_push         = 1'b1;
                o_cmd.is_start = 1'b0;
                o_cmd.value    = i_in.data_byte;
                o_cmd.closes   = (r_rem == REM_W'(1));
                n_rem          = r_rem - REM_W'(1);
                if (r_rem == REM_W'(1)) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_rem  <= '0;
        end else begin
            r_open <= n_open;
            r_rem  <= n_rem;
        end
    end

endmodule

>>> src/fbsac_queue.sv
// Small command FIFO that decouples the front end from the serializer.
module fbsac_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fbsac_pkg::t_cmd     i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output fbsac_pkg::t_cmd     o_cmd
);
    import fbsac_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + QPTR_W'(1);
            if (do_pop)  r_rp <= r_rp + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> src/fbsac_back.sv
// Back end: serializes each command into frame bytes and keeps both checks.
module fbsac_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fbsac_pkg::t_cmd     i_cmd,
    output logic                o_pop,
    fbsac_out_if.source         o_out
);
    import fbsac_pkg::*;

    logic             r_busy;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_sum, r_add;
    logic             r_out_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic             emit, finish;
    logic [IDX_W-1:0] ndata;
    logic [7:0]       data_b, base_sum, base_add, n_sum, n_add, e_byte;
    logic             e_last;

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_byte;
    assign o_out.last_of_frame = r_last;

    assign emit  = r_busy && (!r_out_valid || o_out.ready);
    assign o_pop = i_valid && (!r_busy || finish);
    assign ndata = r_cmd.is_start ? HDR_BYTES : PAY_BYTES;

    always_comb begin
        data_b = r_cmd.value;
        if (r_cmd.is_start) begin
            case (r_idx)
                IDX_SYNC0: data_b = HDR_SYNC0;
                IDX_SYNC1: data_b = HDR_SYNC1;
                IDX_FUNC:  data_b = r_cmd.value;
                IDX_LEN:   data_b = r_cmd.len;
                default:   data_b = r_cmd.value;
            endcase
        end
        // a frame's checks restart with its first header byte
        base_sum = (r_cmd.is_start && r_idx == IDX_SYNC0) ? 8'd0 : r_sum;
        base_add = (r_cmd.is_start && r_idx == IDX_SYNC0) ? 8'd0 : r_add;
        n_sum    = base_sum + data_b;
        n_add    = base_add + n_sum;

        e_byte = data_b;
        e_last = 1'b0;
        finish = 1'b0;
        if (r_idx < ndata) begin
            finish = emit && (r_idx == ndata - IDX_W'(1)) && !r_cmd.closes;
        end else if (r_idx == ndata) begin
            e_byte = r_sum;
        end else begin
            e_byte = r_add;
            e_last = 1'b1;
            finish = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= e_byte;
            r_last <= e_last;
            if (r_idx < ndata) begin
                r_sum <= n_sum;
                r_add <= n_add;
            end
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

endmodule

>>> src/frame_builder_sum_add_check_unit.sv
// Top level: telemetry frame builder with sum and add check bytes.
// Each input word is classified by the front end (start, payload in frame, or
// stray payload, which is dropped) and queued in a four-entry command FIFO; the
// serializer then emits one frame byte per cycle, while the output accepts them,
// into a registered output stage. A payload word yields one byte, or three when it
// closes the frame; a start word yields four, or six for an empty frame. The next
// command is loaded in the cycle that emits the last byte of the current one, so
// only an idle serializer adds a load step: a word accepted into an empty block
// passes the FIFO, command and output registers before its first byte shows. The
// input keeps accepting while the FIFO has room, so short bursts are absorbed while
// the output stalls. last_of_frame marks the add-check byte ending a completed frame.
module frame_builder_sum_add_check_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbsac_in_if.sink     i_in,
    fbsac_out_if.source  o_out
);
    import fbsac_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    t_cmd push_cmd, head_cmd;

    fbsac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    fbsac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    fbsac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

>>> src/fbsac_checker.sv
// Port-level checker for the frame builder and its bind to the top level.
module fbsac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    logic r_prev_last;
    logic out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    // last flag of the previously delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b0;
        end else if (out_acc) begin
            r_prev_last <= i_out_last;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled output word changed");

    a_frame_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && i_out_last |-> !r_prev_last)
        else $error("two frame ends in consecutive words");

endmodule

bind frame_builder_sum_add_check_unit fbsac_checker u_fbsac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_frame)
);
